### hdl/ddsl_pkg.sv
// Shared types, constants and arithmetic helpers for the setpoint limiter.
package ddsl_pkg;

  localparam int unsigned CMD_W   = 24;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned SP_W    = 17;
  localparam int unsigned MIX_W   = 18;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [LIM_W-1:0] RST_MAX_TRANS = 16'd2000;
  localparam logic [LIM_W-1:0] RST_MAX_ROT   = 16'd1400;
  localparam logic [LIM_W-1:0] RST_MAX_WHEEL = 16'd3000;
  localparam logic [LIM_W-1:0] RST_MAX_ACCEL = 16'd8;
  localparam logic [LIM_W-1:0] RST_MAX_DECEL = 16'd4;

  // register indexes, word addressed
  typedef enum logic [2:0] {
    REG_ENABLED   = 3'd0,
    REG_MAX_TRANS = 3'd1,
    REG_MAX_ROT   = 3'd2,
    REG_MAX_WHEEL = 3'd3,
    REG_MAX_ACCEL = 3'd4,
    REG_MAX_DECEL = 3'd5
  } ddsl_reg_idx_t;

  typedef struct packed {
    logic             enabled;
    logic [LIM_W-1:0] max_trans;
    logic [LIM_W-1:0] max_rot;
    logic [LIM_W-1:0] max_wheel;
    logic [LIM_W-1:0] max_accel;
    logic [LIM_W-1:0] max_decel;
  } ddsl_cfg_t;

  // clamp a raw command symmetrically to lim
  function automatic logic signed [SP_W-1:0] clamp_cmd(
    input logic signed [CMD_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [CMD_W:0] vx;
    logic signed [CMD_W:0] lx;
    logic signed [SP_W-1:0] ls;
    vx = {v[CMD_W-1], v};
    lx = {{(CMD_W+1-LIM_W){1'b0}}, lim};
    ls = {1'b0, lim};
    if (vx > lx) begin
      clamp_cmd = ls;
    end else if (vx < -lx) begin
      clamp_cmd = -ls;
    end else begin
      clamp_cmd = v[SP_W-1:0];
    end
  endfunction

  // clamp a mixed wheel value symmetrically to lim
  function automatic logic signed [SP_W-1:0] clamp_mix(
    input logic signed [MIX_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [MIX_W:0] vx;
    logic signed [MIX_W:0] lx;
    logic signed [SP_W-1:0] ls;
    vx = {v[MIX_W-1], v};
    lx = {{(MIX_W+1-LIM_W){1'b0}}, lim};
    ls = {1'b0, lim};
    if (vx > lx) begin
      clamp_mix = ls;
    end else if (vx < -lx) begin
      clamp_mix = -ls;
    end else begin
      clamp_mix = v[SP_W-1:0];
    end
  endfunction

  // limit the step from prev toward target; result lies between the two
  function automatic logic signed [SP_W-1:0] slew(
    input logic signed [SP_W-1:0] target,
    input logic signed [SP_W-1:0] prev,
    input logic [LIM_W-1:0]       accel,
    input logic [LIM_W-1:0]       decel
  );
    logic signed [MIX_W:0] tx;
    logic signed [MIX_W:0] px;
    logic signed [MIX_W:0] ax;
    logic signed [MIX_W:0] dx;
    logic signed [MIX_W:0] up;
    logic signed [MIX_W:0] dn;
    tx = {{(MIX_W+1-SP_W){target[SP_W-1]}}, target};
    px = {{(MIX_W+1-SP_W){prev[SP_W-1]}}, prev};
    ax = {{(MIX_W+1-LIM_W){1'b0}}, accel};
    dx = {{(MIX_W+1-LIM_W){1'b0}}, decel};
    up = px + ax;
    dn = px - dx;
    if (tx - px > ax) begin
      slew = up[SP_W-1:0];
    end else if (px - tx > dx) begin
      slew = dn[SP_W-1:0];
    end else begin
      slew = target;
    end
  endfunction

endpackage

### hdl/diff_drive_setpoint_limiter.sv
// Top level: clamp, mix and slew limit wheel setpoints, one item per cycle while the output is not stalled.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_translation_cmd, in_rotation_cmd
//   out_     output     out_valid/out_stall out_left_setpoint, out_right_setpoint
//   cfg      input      psel/penable/pready paddr, pwdata, prdata
//
// An accepted item is captured in the input register, and its result is loaded into
// the output register through the single clamp/mix/slew pass between the registers;
// one item per cycle is sustained while no stalled result holds the input register.
// The output register doubles as the previous setpoint, cleared by reset.
// A stalled result holds the input register; in_stall rises only then.
// With enabled low an item is taken and dropped without a result.
module diff_drive_setpoint_limiter
  import ddsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [CMD_W-1:0] in_translation_cmd,
  input  logic signed [CMD_W-1:0] in_rotation_cmd,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [SP_W-1:0] out_left_setpoint,
  output logic signed [SP_W-1:0] out_right_setpoint,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  ddsl_cfg_t cfg;

  logic                    s1_valid_r;
  logic signed [CMD_W-1:0] s1_trans_r;
  logic signed [CMD_W-1:0] s1_rot_r;
  logic                    out_valid_r;
  logic signed [SP_W-1:0]  left_r;
  logic signed [SP_W-1:0]  right_r;

  logic                    fire;
  logic signed [SP_W-1:0]  t_clamp;
  logic signed [SP_W-1:0]  r_clamp;
  logic signed [MIX_W-1:0] left_mix;
  logic signed [MIX_W-1:0] right_mix;
  logic signed [SP_W-1:0]  left_nxt;
  logic signed [SP_W-1:0]  right_nxt;

  ddsl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // hold the input register while a full output waits
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign fire     = s1_valid_r && !in_stall;

  // capture next item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_trans_r <= in_translation_cmd;
      s1_rot_r   <= in_rotation_cmd;
    end
  end

  // clamp commands, mix, clamp wheels, slew against last setpoint
  always_comb begin
    t_clamp   = clamp_cmd(s1_trans_r, cfg.max_trans);
    r_clamp   = clamp_cmd(s1_rot_r, cfg.max_rot);
    left_mix  = {t_clamp[SP_W-1], t_clamp} - {r_clamp[SP_W-1], r_clamp};
    right_mix = {t_clamp[SP_W-1], t_clamp} + {r_clamp[SP_W-1], r_clamp};
    left_nxt  = slew(clamp_mix(left_mix, cfg.max_wheel), left_r,
                     cfg.max_accel, cfg.max_decel);
    right_nxt = slew(clamp_mix(right_mix, cfg.max_wheel), right_r,
                     cfg.max_accel, cfg.max_decel);
  end

  // load result and previous setpoint; drop item when disabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
      right_r     <= '0;
    end else if (fire && cfg.enabled) begin
      out_valid_r <= 1'b1;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_setpoint  = left_r;
  assign out_right_setpoint = right_r;

endmodule

### hdl/ddsl_regs.sv
// Configuration register file behind the APB-style port.
module ddsl_regs
  import ddsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output ddsl_cfg_t         cfg
);

  ddsl_cfg_t     cfg_r;
  logic          wr_en;
  ddsl_reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ddsl_reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  // write selected register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled   <= 1'b1;
      cfg_r.max_trans <= RST_MAX_TRANS;
      cfg_r.max_rot   <= RST_MAX_ROT;
      cfg_r.max_wheel <= RST_MAX_WHEEL;
      cfg_r.max_accel <= RST_MAX_ACCEL;
      cfg_r.max_decel <= RST_MAX_DECEL;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLED:   cfg_r.enabled   <= pwdata[0];
        REG_MAX_TRANS: cfg_r.max_trans <= pwdata[LIM_W-1:0];
        REG_MAX_ROT:   cfg_r.max_rot   <= pwdata[LIM_W-1:0];
        REG_MAX_WHEEL: cfg_r.max_wheel <= pwdata[LIM_W-1:0];
        REG_MAX_ACCEL: cfg_r.max_accel <= pwdata[LIM_W-1:0];
        REG_MAX_DECEL: cfg_r.max_decel <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // return selected register
  always_comb begin
    case (idx)
      REG_ENABLED:   prdata = {{(DATA_W-1){1'b0}}, cfg_r.enabled};
      REG_MAX_TRANS: prdata = {{(DATA_W-LIM_W){1'b0}}, cfg_r.max_trans};
      REG_MAX_ROT:   prdata = {{(DATA_W-LIM_W){1'b0}}, cfg_r.max_rot};
      REG_MAX_WHEEL: prdata = {{(DATA_W-LIM_W){1'b0}}, cfg_r.max_wheel};
      REG_MAX_ACCEL: prdata = {{(DATA_W-LIM_W){1'b0}}, cfg_r.max_accel};
      REG_MAX_DECEL: prdata = {{(DATA_W-LIM_W){1'b0}}, cfg_r.max_decel};
      default:       prdata = '0;
    endcase
  end

endmodule

### hdl/ddsl_checker.sv
// Port-level checks for the setpoint limiter, bound to the top level.
module ddsl_checker
  import ddsl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [SP_W-1:0] out_left_setpoint,
  input logic signed [SP_W-1:0] out_right_setpoint
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // a fresh result comes from an item accepted earlier through the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching item");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left_setpoint)
                                  && $stable(out_right_setpoint)))
    else $error("stalled result changed");

endmodule

bind diff_drive_setpoint_limiter ddsl_checker u_ddsl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_left_setpoint  (out_left_setpoint),
  .out_right_setpoint (out_right_setpoint)
);
